>>> hdl/dip_pkg.sv
// ----------------------------------------------------------------------------
// dip_pkg
// shared types and constants for the dotted ipv4 text parser
// ----------------------------------------------------------------------------
package dip_pkg;

  // where the parser stands inside the current part
  typedef enum logic [1:0] {
    PH_START  = 2'd0,
    PH_ZERO   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_e;

  // radix of the current part
  typedef enum logic [1:0] {
    RAD_DEC = 2'd0,
    RAD_OCT = 2'd1,
    RAD_HEX = 2'd2
  } radix_e;

  localparam logic [31:0] ADDR_NONE  = 32'hffff_ffff;
  localparam logic [31:0] LIMIT_8B   = 32'h0000_00ff;
  localparam logic [31:0] LIMIT_16B  = 32'h0000_ffff;
  localparam logic [31:0] LIMIT_24B  = 32'h00ff_ffff;

  localparam logic [1:0]  PARTS_MAX  = 2'd3;

  localparam logic [7:0]  CHR_NUL    = 8'h00;
  localparam logic [7:0]  CHR_0      = 8'h30;
  localparam logic [7:0]  CHR_9      = 8'h39;
  localparam logic [7:0]  CHR_LA     = 8'h61;
  localparam logic [7:0]  CHR_LF     = 8'h66;
  localparam logic [7:0]  CHR_UA     = 8'h41;
  localparam logic [7:0]  CHR_UF     = 8'h46;
  localparam logic [7:0]  CHR_LX     = 8'h78;
  localparam logic [7:0]  CHR_UX     = 8'h58;
  localparam logic [7:0]  CHR_DOT    = 8'h2e;
  localparam logic [7:0]  CHR_SPACE  = 8'h20;
  localparam logic [7:0]  CHR_TAB    = 8'h09;
  localparam logic [7:0]  CHR_CR     = 8'h0d;

endpackage

>>> hdl/dotted_ipv4_text_parser_core.sv
// ----------------------------------------------------------------------------
// dotted_ipv4_text_parser_core
// character-serial parser of dotted ipv4 address text (classic inet_addr)
// ----------------------------------------------------------------------------
// usage
//   input channel: one text character per request (text_char_i, last_char_i)
//   under in_valid_i / in_ready_o. a NUL ends the text, last_char_i marks
//   the final character and triggers exactly one result.
//   output channel: one result request (address_o, is_valid_o) under
//   out_valid_o / out_ready_i for each text. an invalid text gives
//   address 0xffffffff with is_valid_o low.
//   timing: a request is captured in the input register and parsed in the
//   following cycle; for a last character the result register loads as the
//   parse stage takes it, and out_valid_o is driven from that register. one
//   character per cycle is sustained unless a last character stalls, the
//   rate set by the single accumulate step (shift-add by the radix) between
//   the registers. characters beyond MAX_CHARS in one text are ignored.
//   reset empties both registers and clears parse state but the stored parts.
//   stall: while the result register is full and not taken, a last
//   character waits in the input register; other characters keep flowing.
// ----------------------------------------------------------------------------
module dotted_ipv4_text_parser_core #(
  parameter int MAX_CHARS = 28
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_char_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] address_o,
  output logic        is_valid_o
);
  import dip_pkg::*;

  localparam int CntW = $clog2(MAX_CHARS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_CHARS);

  // input register
  logic       in_valid_q;
  logic [7:0] char_q;
  logic       last_q;

  // parse state
  phase_e          phase_q, phase_d;
  radix_e          radix_q, radix_d;
  logic [31:0]     acc_q, acc_d;
  logic [1:0]      parts_q, parts_d;
  logic [7:0]      store_q [3];
  logic [7:0]      store_d [3];
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            stop_q, stop_d;
  logic            err_q, err_d;

  // result register
  logic        out_valid_q;
  logic [31:0] address_q;
  logic        is_valid_q;

  logic        out_free;
  logic        adv;
  logic        active;
  logic        digits_go;
  logic [31:0] acc_base;
  logic [31:0] acc_mul;
  logic [31:0] fin_addr;
  logic        fin_ok;

  // the parse stage moves unless a last character finds the result full
  assign out_free   = !out_valid_q || out_ready_i;
  assign adv        = in_valid_q && (!last_q || out_free);
  assign in_ready_o = !in_valid_q || adv;

  assign active = !stop_q && !err_q && (cnt_q < CntMax);

  // accumulator times radix as shifts and one add
  always_comb begin
    case (radix_d)
      RAD_OCT: acc_mul = acc_base << 3;
      RAD_HEX: acc_mul = acc_base << 4;
      default: acc_mul = (acc_base << 3) + (acc_base << 1);
    endcase
  end

  // one character of parsing
  always_comb begin
    phase_d   = phase_q;
    radix_d   = radix_q;
    acc_d     = acc_q;
    parts_d   = parts_q;
    store_d   = store_q;
    stop_d    = stop_q;
    err_d     = err_q;
    acc_base  = acc_q;
    digits_go = 1'b0;

    if (active) begin
      if (char_q == CHR_NUL) begin
        stop_d = 1'b1;
      end else begin
        digits_go = 1'b1;
        if (phase_q == PH_START) begin
          acc_base = '0;
          acc_d    = '0;
          if (char_q == CHR_0) begin
            phase_d   = PH_ZERO;
            radix_d   = RAD_OCT;
            digits_go = 1'b0;
          end else begin
            phase_d = PH_DIGITS;
            radix_d = RAD_DEC;
          end
        end else if (phase_q == PH_ZERO) begin
          phase_d = PH_DIGITS;
          if (char_q == CHR_LX || char_q == CHR_UX) begin
            radix_d   = RAD_HEX;
            digits_go = 1'b0;
          end
        end

        if (digits_go) begin
          if (char_q inside {[CHR_0:CHR_9]}) begin
            acc_d = acc_mul + {28'd0, char_q[3:0]};
          end else if (radix_d == RAD_HEX &&
                       (char_q inside {[CHR_LA:CHR_LF], [CHR_UA:CHR_UF]})) begin
            // letters a-f: low nibble 1..6 maps to 10..15
            acc_d = acc_mul + {28'd0, char_q[3:0] + 4'd9};
          end else if (char_q == CHR_DOT) begin
            if (parts_q == PARTS_MAX || acc_base > LIMIT_8B) begin
              err_d = 1'b1;
            end else begin
              store_d[parts_q] = acc_base[7:0];
              parts_d          = parts_q + 2'd1;
              acc_d            = '0;
              phase_d          = PH_START;
            end
          end else if (char_q inside {CHR_SPACE, [CHR_TAB:CHR_CR]}) begin
            stop_d = 1'b1;
          end else begin
            err_d = 1'b1;
          end
        end
      end
    end
  end

  assign cnt_d = (cnt_q < CntMax) ? cnt_q + CntW'(1) : cnt_q;

  // the last part fills what the earlier parts leave free
  always_comb begin
    fin_ok   = !err_d;
    fin_addr = acc_d;
    case (parts_d)
      2'd0: begin
        fin_addr = acc_d;
      end
      2'd1: begin
        if (acc_d > LIMIT_24B) fin_ok = 1'b0;
        fin_addr = acc_d | {store_d[0], 24'd0};
      end
      2'd2: begin
        if (acc_d > LIMIT_16B) fin_ok = 1'b0;
        fin_addr = acc_d | {store_d[0], store_d[1], 16'd0};
      end
      default: begin
        if (acc_d > LIMIT_8B) fin_ok = 1'b0;
        fin_addr = acc_d | {store_d[0], store_d[1], store_d[2], 8'd0};
      end
    endcase
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      char_q <= text_char_i;
      last_q <= last_char_i;
    end
  end

  // parse state, cleared after each text
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      radix_q <= RAD_DEC;
      acc_q   <= '0;
      parts_q <= '0;
      cnt_q   <= '0;
      stop_q  <= 1'b0;
      err_q   <= 1'b0;
    end else if (adv) begin
      if (last_q) begin
        phase_q <= PH_START;
        radix_q <= RAD_DEC;
        acc_q   <= '0;
        parts_q <= '0;
        cnt_q   <= '0;
        stop_q  <= 1'b0;
        err_q   <= 1'b0;
      end else begin
        phase_q <= phase_d;
        radix_q <= radix_d;
        acc_q   <= acc_d;
        parts_q <= parts_d;
        cnt_q   <= cnt_d;
        stop_q  <= stop_d;
        err_q   <= err_d;
      end
    end
  end

  // stored parts need no reset: read only after written in the same text
  always_ff @(posedge clk_i) begin
    if (adv) begin
      store_q <= store_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= adv && last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && last_q) begin
      address_q  <= fin_ok ? fin_addr : ADDR_NONE;
      is_valid_q <= fin_ok;
    end
  end

  assign out_valid_o = out_valid_q;
  assign address_o   = address_q;
  assign is_valid_o  = is_valid_q;

  // a finished text always lands in the result register
  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && last_q |=> out_valid_q)
    else $error("last character did not produce a result");

  // a failed parse always reports the none address
  a_invalid_none: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !is_valid_q |-> address_q == ADDR_NONE)
    else $error("invalid result without none address");

  // parse state starts fresh for the next text
  a_state_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && last_q |=> cnt_q == '0 && parts_q == '0 && !err_q && !stop_q)
    else $error("parse state not cleared after text");

  // character count saturates at the limit
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntMax)
    else $error("character count beyond limit");

endmodule
